// ===== rtl/two_level_page_table_walker_defines.svh =====
// Assertion macros used by the walker's checker.
`ifndef TWO_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH
`define TWO_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define PTW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define PTW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ptw_pkg.sv =====
package ptw_pkg;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned FRAME_W    = 20;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned OFS_W      = 12;
  localparam int unsigned DIR_SHIFT  = 22;
  localparam int unsigned TAB_SHIFT  = 12;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;

  localparam logic [ADDR_W-1:0] FRAME_MASK = 32'hFFFF_F000;
  localparam int unsigned       PRESENT_BIT = 0;

  // Configuration register indexes
  localparam logic REG_DIR_BASE = 1'b0;

  // Request and result codes
  localparam logic REQ_TRANSLATE = 1'b0;
  localparam logic REQ_RESPONSE  = 1'b1;
  localparam logic RES_READ      = 1'b0;
  localparam logic RES_DONE      = 1'b1;

  typedef enum logic [1:0] {
    PHASE_IDLE = 2'd0,
    PHASE_DIR  = 2'd1,
    PHASE_TAB  = 2'd2
  } walk_phase_t;

  typedef struct packed {
    logic              req_type;
    logic [ADDR_W-1:0] vaddr;
    logic [ADDR_W-1:0] read_data;
  } in_item_t;

  typedef struct packed {
    logic              res_type;
    logic [ADDR_W-1:0] read_addr;
    logic [ADDR_W-1:0] phys_addr;
    logic              fault;
  } out_item_t;

  typedef struct packed {
    logic      vld;
    out_item_t item;
  } walk_res_t;

  function automatic logic entry_usable(input logic [ADDR_W-1:0] e);
    return e[PRESENT_BIT] && ((e & FRAME_MASK) != '0);
  endfunction

endpackage

// ===== rtl/ptw_walk.sv =====
module ptw_walk (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  ptw_pkg::in_item_t          item,
  input  logic [ptw_pkg::FRAME_W-1:0] dir_base,
  output ptw_pkg::walk_res_t         res
);

  ptw_pkg::walk_phase_t              phase_r, phase_nxt;
  logic [ptw_pkg::ADDR_W-1:0]        saved_vaddr_r, saved_vaddr_nxt;
  logic                              busy;
  logic [ptw_pkg::IDX_W-1:0]         dir_idx;
  logic [ptw_pkg::IDX_W-1:0]         tab_idx;
  logic [ptw_pkg::ADDR_W-1:0]        entry_frame;

  assign dir_idx     = item.vaddr[ptw_pkg::DIR_SHIFT +: ptw_pkg::IDX_W];
  assign tab_idx     = saved_vaddr_r[ptw_pkg::TAB_SHIFT +: ptw_pkg::IDX_W];
  assign entry_frame = item.read_data & ptw_pkg::FRAME_MASK;

  always_comb begin
    unique case (phase_r)
      ptw_pkg::PHASE_DIR, ptw_pkg::PHASE_TAB: busy = 1'b1;
      default:                                busy = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    phase_nxt       = phase_r;
    saved_vaddr_nxt = saved_vaddr_r;
    if (item.req_type == ptw_pkg::REQ_TRANSLATE) begin
      if (!busy) begin
        phase_nxt       = ptw_pkg::PHASE_DIR;
        saved_vaddr_nxt = item.vaddr;
      end
    end else if (busy) begin
      if (!ptw_pkg::entry_usable(item.read_data) || phase_r == ptw_pkg::PHASE_TAB) begin
        phase_nxt = ptw_pkg::PHASE_IDLE;
      end else begin
        phase_nxt = ptw_pkg::PHASE_TAB;
      end
    end
  end

  // Result
  always_comb begin
    res.vld            = 1'b0;
    res.item.res_type  = ptw_pkg::RES_READ;
    res.item.read_addr = '0;
    res.item.phys_addr = '0;
    res.item.fault     = 1'b0;
    if (item.req_type == ptw_pkg::REQ_TRANSLATE) begin
      if (!busy) begin
        res.vld            = 1'b1;
        res.item.read_addr = {dir_base, dir_idx, 2'b00};
      end
    end else if (busy) begin
      res.vld = 1'b1;
      if (!ptw_pkg::entry_usable(item.read_data)) begin
        res.item.res_type = ptw_pkg::RES_DONE;
        res.item.fault    = 1'b1;
      end else if (phase_r == ptw_pkg::PHASE_DIR) begin
        res.item.read_addr = entry_frame | {20'b0, tab_idx, 2'b00};
      end else begin
        res.item.res_type  = ptw_pkg::RES_DONE;
        res.item.phys_addr = entry_frame
                           | {20'b0, saved_vaddr_r[ptw_pkg::OFS_W-1:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= ptw_pkg::PHASE_IDLE;
      saved_vaddr_r <= '0;
    end else if (step) begin
      phase_r       <= phase_nxt;
      saved_vaddr_r <= saved_vaddr_nxt;
    end
  end

endmodule

// ===== rtl/two_level_page_table_walker.sv =====
// Two-level page table walker, 4 KB pages. Each request (a translate request
// or a memory read response) goes through one input register, combinational
// decode/add/check logic and one output register, so one request per cycle
// is sustained; out_valid rises once the request has passed the input and
// then the output register. The only limit on rate is the output register:
// when it holds a result that the consumer stalls, the input register stops
// advancing and, with a request held there, in_stall rises.
// A translate request asks for the directory word at dir_base*4096 + va[31:22]*4;
// the response either faults (present clear or frame zero) or asks for the
// table word at frame + va[21:12]*4; the second response faults the same way
// or finishes with frame | va[11:0]. Translate requests while a walk is open,
// and responses while idle, are consumed with no result. dir_base_frame sits
// at byte address 0 of the APB port and is sampled when a walk starts.
module two_level_page_table_walker (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  ptw_pkg::in_item_t             in_data,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output ptw_pkg::out_item_t            out_data,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ptw_pkg::PADDR_W-1:0]   paddr,
  input  logic [ptw_pkg::PDATA_W-1:0]   pwdata,
  output logic [ptw_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  logic                           in_vld_r;
  ptw_pkg::in_item_t              in_item_r;
  logic                           out_vld_r;
  ptw_pkg::out_item_t             out_item_r;
  logic [ptw_pkg::FRAME_W-1:0]    dir_base_r;
  logic                           advance;
  logic                           reg_sel;
  ptw_pkg::walk_res_t             walk_res;

  // Advance the held request when the output register is free or drains now.
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  // Hold new requests only while the input register cannot move.
  assign in_stall = in_vld_r && !advance;

  assign reg_sel = paddr[ptw_pkg::PADDR_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_data;
    end
  end

  ptw_walk u_walk (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .item     (in_item_r),
    .dir_base (dir_base_r),
    .res      (walk_res)
  );

  // Load a result on advance; drop the valid once the consumer takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= walk_res.vld;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && walk_res.vld) begin
      out_item_r <= walk_res.item;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  // Configuration register; writes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_base_r <= '0;
    end else if (psel && penable && pwrite && pready
                 && reg_sel == ptw_pkg::REG_DIR_BASE) begin
      dir_base_r <= pwdata[ptw_pkg::FRAME_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel == ptw_pkg::REG_DIR_BASE) begin
      prdata = {{(ptw_pkg::PDATA_W - ptw_pkg::FRAME_W){1'b0}}, dir_base_r};
    end
  end

  assign pready = 1'b1;

endmodule

// ===== rtl/ptw_checker.sv =====
`include "two_level_page_table_walker_defines.svh"

module ptw_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input ptw_pkg::out_item_t out_data,
  input logic               pready
);

  logic in_acc;

  assign in_acc = in_valid && !in_stall;

  `PTW_ASSERT_NOW(a_pready_high, clk, rst_n, 1'b1, pready, "pready dropped")
  `PTW_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `PTW_ASSERT_NOW(a_read_clean, clk, rst_n, out_valid && out_data.res_type == ptw_pkg::RES_READ, !out_data.fault && out_data.phys_addr == '0, "read request carries done fields")
  `PTW_ASSERT_NOW(a_done_clean, clk, rst_n, out_valid && out_data.res_type == ptw_pkg::RES_DONE, out_data.read_addr == '0 && !(out_data.fault && out_data.phys_addr != '0), "finished walk carries stray fields")
  `PTW_ASSERT_NEXT(a_no_spont_out, clk, rst_n, !out_valid && !in_acc && !$past(in_acc), !out_valid, "result with no request behind it")

endmodule

bind two_level_page_table_walker ptw_checker u_ptw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .pready    (pready)
);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

  // Cycles with no request, result or register access before the run is abandoned.
  localparam int unsigned IDLE_LIMIT = 2000;
  // Cycles to let pass after the last result so dropped requests can settle.
  localparam int unsigned SETTLE_CYCLES = 8;
  // Length of the one long result hold-off that backs the walker up.
  localparam int unsigned LONG_HOLD = 150;
  localparam int unsigned PHASE_WALK_REQS = 138;

  localparam logic [ptw_pkg::PADDR_W-1:0] DIR_BASE_ADDR =
    ptw_pkg::PADDR_W'({ptw_pkg::REG_DIR_BASE, 2'b00});
  // Byte address one register past the last one; writes there must be ignored.
  localparam logic [ptw_pkg::PADDR_W-1:0] SPARE_ADDR = ptw_pkg::PADDR_W'(3'd4);

  logic                         clk       = 1'b0;
  logic                         rst_n     = 1'b0;
  logic                         in_valid  = 1'b0;
  logic                         in_stall;
  ptw_pkg::in_item_t            in_data   = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  ptw_pkg::out_item_t           out_data;
  logic                         psel      = 1'b0;
  logic                         penable   = 1'b0;
  logic                         pwrite    = 1'b0;
  logic [ptw_pkg::PADDR_W-1:0]  paddr     = '0;
  logic [ptw_pkg::PDATA_W-1:0]  pwdata    = '0;
  logic [ptw_pkg::PDATA_W-1:0]  prdata;
  logic                         pready;

  two_level_page_table_walker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Walk state as the testbench tracks it: phase, latched virtual address and
  // the directory base that the next translate request will pick up.
  // ---------------------------------------------------------------------------
  ptw_pkg::walk_phase_t                walk_phase = ptw_pkg::PHASE_IDLE;
  logic [ptw_pkg::ADDR_W-1:0]          walk_vaddr = '0;
  logic [ptw_pkg::FRAME_W-1:0]         dir_base   = '0;

  ptw_pkg::in_item_t                   requests_to_send[$];
  ptw_pkg::out_item_t                  walk_results_due[$];

  int unsigned items_queued    = 0;
  int unsigned items_accepted  = 0;
  int unsigned results_checked = 0;
  int unsigned entry_reads     = 0;
  int unsigned translations    = 0;
  int unsigned faults          = 0;
  int unsigned base_settings   = 0;
  int unsigned errors          = 0;

  // Advance the walk by one accepted request; return 1 with the result it
  // produces, or 0 when the request is dropped.
  function automatic bit walk_advance(input ptw_pkg::in_item_t req,
                                      output ptw_pkg::out_item_t res);
    logic                        busy;
    logic [ptw_pkg::ADDR_W-1:0]  entry;
    res   = '0;
    busy  = (walk_phase == ptw_pkg::PHASE_DIR) || (walk_phase == ptw_pkg::PHASE_TAB);
    entry = req.read_data;
    if (req.req_type == ptw_pkg::REQ_TRANSLATE) begin
      // A translate request while a walk is open is dropped.
      if (busy) return 1'b0;
      walk_vaddr    = req.vaddr;
      walk_phase    = ptw_pkg::PHASE_DIR;
      res.res_type  = ptw_pkg::RES_READ;
      res.read_addr = {dir_base, req.vaddr[ptw_pkg::ADDR_W-1 -: ptw_pkg::IDX_W], 2'b00};
      return 1'b1;
    end
    // A memory response with no walk open is dropped.
    if (!busy) return 1'b0;
    if (!entry[ptw_pkg::PRESENT_BIT]
        || entry[ptw_pkg::ADDR_W-1 -: ptw_pkg::FRAME_W] == '0) begin
      walk_phase   = ptw_pkg::PHASE_IDLE;
      res.res_type = ptw_pkg::RES_DONE;
      res.fault    = 1'b1;
      return 1'b1;
    end
    if (walk_phase == ptw_pkg::PHASE_DIR) begin
      walk_phase    = ptw_pkg::PHASE_TAB;
      res.res_type  = ptw_pkg::RES_READ;
      res.read_addr = {entry[ptw_pkg::ADDR_W-1 -: ptw_pkg::FRAME_W],
                       walk_vaddr[ptw_pkg::DIR_SHIFT-1 -: ptw_pkg::IDX_W], 2'b00};
      return 1'b1;
    end
    walk_phase    = ptw_pkg::PHASE_IDLE;
    res.res_type  = ptw_pkg::RES_DONE;
    res.phys_addr = {entry[ptw_pkg::ADDR_W-1 -: ptw_pkg::FRAME_W],
                     walk_vaddr[ptw_pkg::OFS_W-1:0]};
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: bursts of random length separated by random gaps. A
  // request stays on the bus, unchanged, until the walker takes it.
  // ---------------------------------------------------------------------------
  logic        in_taken   = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      burst_left = 0;
    end else if (in_valid && !in_taken) begin
      // hold the stalled request
    end else if (burst_left != 0 && requests_to_send.size() != 0) begin
      in_valid <= 1'b1;
      in_data  <= requests_to_send.pop_front();
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      if (gap_left != 0) begin
        gap_left--;
      end else begin
        burst_left = $urandom_range(24, 1);
        // Roughly a third of the bursts run straight into the next one.
        gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(6, 1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result stall: a pattern of its own whose density changes with each
  // random-length window, some windows stall-free, plus one long hold-off
  // once the walker has work queued behind it.
  // ---------------------------------------------------------------------------
  int unsigned stall_pct   = 0;
  int unsigned window_left = 0;
  int unsigned hold_left   = 0;
  bit          held_once   = 1'b0;

  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!held_once && results_checked >= 300 && requests_to_send.size() > 40) begin
      held_once = 1'b1;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else begin
      if (window_left == 0) begin
        window_left = $urandom_range(80, 16);
        stall_pct   = ($urandom_range(2) == 0) ? 0 : $urandom_range(85, 10);
      end else begin
        window_left--;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each accepted result against the oldest one due, then
  // advance the walk for any request taken at the same edge.
  // ---------------------------------------------------------------------------
  ptw_pkg::out_item_t got_res;
  ptw_pkg::out_item_t want_res;
  ptw_pkg::out_item_t new_res;

  always @(posedge clk) begin
    in_taken = rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got_res = out_data;
        results_checked++;
        if (walk_results_due.size() == 0) begin
          $error("result with nothing due: type %0d addr %h phys %h fault %0d",
                 got_res.res_type, got_res.read_addr, got_res.phys_addr, got_res.fault);
          errors++;
        end else begin
          want_res = walk_results_due.pop_front();
          if (got_res.res_type !== want_res.res_type) begin
            $error("res_type: expected %0d, got %0d", want_res.res_type, got_res.res_type);
            errors++;
          end
          if (got_res.read_addr !== want_res.read_addr) begin
            $error("read_addr: expected %h, got %h", want_res.read_addr, got_res.read_addr);
            errors++;
          end
          if (got_res.phys_addr !== want_res.phys_addr) begin
            $error("phys_addr: expected %h, got %h", want_res.phys_addr, got_res.phys_addr);
            errors++;
          end
          if (got_res.fault !== want_res.fault) begin
            $error("fault: expected %0d, got %0d", want_res.fault, got_res.fault);
            errors++;
          end
          if (want_res.res_type == ptw_pkg::RES_READ) entry_reads++;
          else if (want_res.fault) faults++;
          else translations++;
        end
      end
      if (in_taken) begin
        items_accepted++;
        if (walk_advance(in_data, new_res)) walk_results_due.push_back(new_res);
      end
    end
  end

  // Watchdog: abandon the run when nothing moves for too long.
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      idle_cycles = 0;
    end else if (rst_n) begin
      idle_cycles++;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Queue one request; the field the walker ignores carries random filler.
  task automatic queue_request(input logic kind, input logic [ptw_pkg::ADDR_W-1:0] value);
    ptw_pkg::in_item_t req;
    req.req_type  = kind;
    req.vaddr     = (kind == ptw_pkg::REQ_TRANSLATE) ? value : ptw_pkg::ADDR_W'($urandom);
    req.read_data = (kind == ptw_pkg::REQ_RESPONSE) ? value : ptw_pkg::ADDR_W'($urandom);
    requests_to_send.push_back(req);
    items_queued++;
  endtask

  function automatic logic [ptw_pkg::ADDR_W-1:0] usable_entry();
    logic [ptw_pkg::FRAME_W-1:0] frame;
    logic [ptw_pkg::OFS_W-2:0]   flags;
    frame = ($urandom_range(15) == 0) ? '1 : ptw_pkg::FRAME_W'($urandom);
    if (frame == '0) frame = ptw_pkg::FRAME_W'(1);
    flags = $urandom;
    return {frame, flags, 1'b1};
  endfunction

  // Entry that must fault: present clear, frame zero, or both.
  function automatic logic [ptw_pkg::ADDR_W-1:0] faulting_entry();
    logic [ptw_pkg::ADDR_W-1:0] word;
    word = $urandom;
    case ($urandom_range(2))
      0: word[ptw_pkg::PRESENT_BIT] = 1'b0;
      1: begin
        word[ptw_pkg::ADDR_W-1 -: ptw_pkg::FRAME_W] = '0;
        word[ptw_pkg::PRESENT_BIT]                  = 1'b1;
      end
      default: word = '0;
    endcase
    return word;
  endfunction

  function automatic logic [ptw_pkg::ADDR_W-1:0] walk_entry();
    return ($urandom_range(7) == 0) ? faulting_entry() : usable_entry();
  endfunction

  // Mostly complete walks with random content; the rest is stray translate
  // requests, stray responses and translate requests that hit a busy walk.
  task automatic queue_random_walks(input int unsigned count);
    int unsigned made;
    int unsigned pick;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        queue_request(ptw_pkg::REQ_TRANSLATE, ptw_pkg::ADDR_W'($urandom));
        if ($urandom_range(9) == 0) begin
          queue_request(ptw_pkg::REQ_TRANSLATE, ptw_pkg::ADDR_W'($urandom));
        end
        queue_request(ptw_pkg::REQ_RESPONSE, walk_entry());
        queue_request(ptw_pkg::REQ_RESPONSE, walk_entry());
        made += 3;
      end else if (pick < 88) begin
        queue_request(ptw_pkg::REQ_TRANSLATE, ptw_pkg::ADDR_W'($urandom));
        made++;
      end else begin
        queue_request(ptw_pkg::REQ_RESPONSE,
                      ($urandom_range(1) == 0) ? usable_entry()
                                               : ptw_pkg::ADDR_W'($urandom));
        made++;
      end
    end
  endtask

  // Wait until every queued request is taken and every result has arrived,
  // then let dropped requests drain out of the pipeline.
  task automatic wait_walker_idle();
    while (items_accepted != items_queued || walk_results_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [ptw_pkg::PADDR_W-1:0] addr,
                            input logic [ptw_pkg::PDATA_W-1:0] wdata,
                            output logic [ptw_pkg::PDATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Program the directory base, poke the unused address (must be ignored),
  // and read the base back.
  task automatic set_dir_base(input logic [ptw_pkg::FRAME_W-1:0] base);
    logic [ptw_pkg::PDATA_W-1:0] rd;
    apb_access(1'b1, DIR_BASE_ADDR, {12'($urandom), base}, rd);
    dir_base = base;
    base_settings++;
    apb_access(1'b1, SPARE_ADDR, ptw_pkg::PDATA_W'($urandom), rd);
    apb_access(1'b0, DIR_BASE_ADDR, '0, rd);
    if (rd[ptw_pkg::FRAME_W-1:0] !== dir_base) begin
      $error("dir_base_frame: expected %h, got %h", dir_base, rd[ptw_pkg::FRAME_W-1:0]);
      errors++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  logic [ptw_pkg::PDATA_W-1:0] reset_base;

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // The base must read back as zero after reset.
    apb_access(1'b0, DIR_BASE_ADDR, '0, reset_base);
    if (reset_base[ptw_pkg::FRAME_W-1:0] !== '0) begin
      $error("dir_base_frame: expected 0, got %h", reset_base[ptw_pkg::FRAME_W-1:0]);
      errors++;
    end

    // Directed walks at the reset base of zero.
    queue_request(ptw_pkg::REQ_RESPONSE,  32'hFFFF_FFFF);  // response with no walk open
    queue_request(ptw_pkg::REQ_TRANSLATE, 32'h0000_0000);
    queue_request(ptw_pkg::REQ_RESPONSE,  32'h0000_0000);  // directory entry absent
    queue_request(ptw_pkg::REQ_TRANSLATE, 32'hFFFF_FFFF);
    queue_request(ptw_pkg::REQ_TRANSLATE, 32'h1234_5678);  // dropped, walk still open
    queue_request(ptw_pkg::REQ_RESPONSE,  32'hFFFF_F001);
    queue_request(ptw_pkg::REQ_RESPONSE,  32'hFFFF_FFFF);  // full walk, all-ones address
    queue_request(ptw_pkg::REQ_TRANSLATE, 32'hFFFF_FFFF);
    queue_request(ptw_pkg::REQ_RESPONSE,  32'h0000_0FFF);  // present but frame zero
    queue_request(ptw_pkg::REQ_TRANSLATE, 32'h0040_0000);
    queue_request(ptw_pkg::REQ_RESPONSE,  32'h0000_1000);  // frame set but not present
    queue_request(ptw_pkg::REQ_TRANSLATE, 32'hAAAA_A555);
    queue_request(ptw_pkg::REQ_RESPONSE,  32'h0000_1001);
    queue_request(ptw_pkg::REQ_RESPONSE,  32'hFFFF_EFFE);  // table entry not present
    queue_request(ptw_pkg::REQ_RESPONSE,  32'h0000_0001);  // response with no walk open
    wait_walker_idle();

    // Directed walks at the top base.
    set_dir_base('1);
    queue_request(ptw_pkg::REQ_TRANSLATE, 32'h0000_0000);
    queue_request(ptw_pkg::REQ_RESPONSE,  32'h5555_5001);
    queue_request(ptw_pkg::REQ_TRANSLATE, 32'h0000_0000);  // dropped, walk still open
    queue_request(ptw_pkg::REQ_RESPONSE,  32'h0000_0001);  // table entry with frame zero
    queue_request(ptw_pkg::REQ_TRANSLATE, 32'h003F_F000);
    queue_request(ptw_pkg::REQ_RESPONSE,  32'h0000_1001);
    queue_request(ptw_pkg::REQ_RESPONSE,  32'h0000_1001);  // lowest usable frames
    queue_request(ptw_pkg::REQ_TRANSLATE, 32'hFFFF_FFFF);
    queue_request(ptw_pkg::REQ_RESPONSE,  32'hFFFF_F001);
    queue_request(ptw_pkg::REQ_RESPONSE,  32'hABCD_E001);
    wait_walker_idle();

    // Random walks, one batch per base; the sender pauses at each boundary
    // until the walker has delivered every result.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        1:       set_dir_base('0);
        3:       set_dir_base('1);
        default: set_dir_base(ptw_pkg::FRAME_W'($urandom));
      endcase
      queue_random_walks(PHASE_WALK_REQS);
      wait_walker_idle();
    end

    $display("covered %0d requests and %0d results over %0d base settings",
             items_accepted, results_checked, base_settings);
    $display("  %0d entry reads, %0d translations, %0d faults, long hold-off %0s",
             entry_reads, translations, faults, held_once ? "done" : "missed");
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
